[src/snfcs_pkg.sv]
package snfcs_pkg;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] address;
    logic [15:0] size;
    logic        link_ok;
    logic [7:0]  status_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  opcode;
    logic        has_address;
    logic [23:0] frame_address;
    logic [15:0] length;
    logic [15:0] data_offset;
    logic        wait_first;
    logic        ok;
    logic        last;
  } out_word_t;

  // classified item passed from the front to the back
  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] address;
    logic [15:0] size;
    logic        link_ok;
    logic [7:0]  status_byte;
    logic        bad;
  } cls_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_WEL  = 2'd1,
    PH_POLL      = 2'd2,
    PH_WAIT_WRDI = 2'd3
  } phase_t;

  localparam logic [2:0] ACT_READ   = 3'd0;
  localparam logic [2:0] ACT_PROG   = 3'd1;
  localparam logic [2:0] ACT_SECTOR = 3'd2;
  localparam logic [2:0] ACT_BLOCK  = 3'd3;
  localparam logic [2:0] ACT_STATUS = 3'd4;

  localparam logic [7:0] OP_READ    = 8'h03;
  localparam logic [7:0] OP_RDSR    = 8'h05;
  localparam logic [7:0] OP_WREN    = 8'h06;
  localparam logic [7:0] OP_WRDI    = 8'h04;
  localparam logic [7:0] OP_SECTOR  = 8'h20;
  localparam logic [7:0] OP_BLOCK   = 8'hD8;
  localparam logic [7:0] OP_PROGRAM = 8'h02;

  localparam logic [1:0] REG_MAX_ADDR = 2'd0;
  localparam logic [1:0] REG_PROG_LIM = 2'd1;
  localparam logic [1:0] REG_SECT_LIM = 2'd2;
  localparam logic [1:0] REG_BLK_LIM  = 2'd3;

endpackage

[src/snfcs_front.sv]
module snfcs_front import snfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  input  logic [23:0] max_address,
  output logic        q_valid,
  input  logic        q_ready,
  output cls_t        q_data
);

  localparam int Depth = 2;

  cls_t       mem_r [Depth];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cls_t       cls;
  logic [24:0] room;

  // request check against the address limit
  always_comb begin
    room = {1'b0, max_address} - {1'b0, in_data.address};
    cls.action      = in_data.action;
    cls.address     = in_data.address;
    cls.size        = in_data.size;
    cls.link_ok     = in_data.link_ok;
    cls.status_byte = in_data.status_byte;
    cls.bad         = room[24] ||
                      ((in_data.action == ACT_READ || in_data.action == ACT_PROG) &&
                       (in_data.size == 16'd0 || {9'd0, in_data.size} > room));
  end

  assign in_ready = (cnt_r != 2'(Depth));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) begin
      wp_nxt = ~wp_r;
    end
    if (q_valid && q_ready) begin
      rp_nxt = ~rp_r;
    end
    cnt_nxt = cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

[src/snfcs_back.sv]
module snfcs_back import snfcs_pkg::*; #(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cls_t        q_data,
  input  logic [11:0] program_poll_limit,
  input  logic [11:0] sector_poll_limit,
  input  logic [11:0] block_poll_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  localparam int PW = $clog2(PAGE_BYTES);
  localparam int CW = PW + 1;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [CW-1:0] chunk_r, chunk_nxt;
  logic [15:0] boff_r, boff_nxt;
  logic [11:0] polls_r, polls_nxt;
  logic        cok_r, cok_nxt;

  // output buffer: up to two words
  out_word_t   ob_r [2];
  logic [1:0]  ocnt_r;
  logic        orp_r;
  out_word_t   w0, w1;
  logic [1:0]  nw;

  logic        take, st_ok, wel, wip_clr;
  logic [11:0] pdec;
  logic [15:0] step;
  logic [CW:0] proom;

  assign q_ready   = (ocnt_r == 2'd0) || (ocnt_r == 2'd1 && out_ready);
  assign take      = q_valid && q_ready;
  assign out_valid = (ocnt_r != 2'd0);
  assign out_data  = ob_r[orp_r];

  function automatic out_word_t frame(logic [7:0] opc, logic ha, logic [23:0] a,
                                      logic [15:0] len, logic [15:0] off, logic wt);
    out_word_t f;
    f.kind = 1'b0; f.opcode = opc; f.has_address = ha; f.frame_address = a;
    f.length = len; f.data_offset = off; f.wait_first = wt; f.ok = 1'b0; f.last = 1'b0;
    return f;
  endfunction

  function automatic out_word_t done(logic okv);
    out_word_t f;
    f = '0;
    f.kind = 1'b1;
    f.ok   = okv;
    return f;
  endfunction

  // sequencer step
  always_comb begin
    phase_nxt = phase_r; op_nxt = op_r; addr_nxt = addr_r; left_nxt = left_r;
    chunk_nxt = chunk_r; boff_nxt = boff_r; polls_nxt = polls_r; cok_nxt = cok_r;
    w0 = '0; w1 = '0; nw = 2'd0;
    st_ok   = q_data.link_ok;
    wel     = st_ok && q_data.status_byte[1];
    wip_clr = st_ok && !q_data.status_byte[0];
    pdec    = polls_r - 12'd1;
    step    = ({{(16-CW){1'b0}}, chunk_r} <= left_r) ? {{(16-CW){1'b0}}, chunk_r} : left_r;
    proom   = (CW+1)'(PAGE_BYTES) - (CW+1)'(q_data.address[PW-1:0]);
    if (q_data.action <= ACT_BLOCK) begin
      if (phase_r == PH_IDLE) begin
        if (q_data.bad) begin
          w0 = done(1'b0); nw = 2'd1;
        end else if (q_data.action == ACT_READ) begin
          w0 = frame(OP_READ, 1'b1, q_data.address, q_data.size, 16'd0, 1'b0);
          w1 = done(1'b1); nw = 2'd2;
        end else begin
          op_nxt   = q_data.action[1:0];
          addr_nxt = q_data.address;
          boff_nxt = 16'd0;
          if (q_data.action == ACT_PROG) begin
            left_nxt  = q_data.size;
            chunk_nxt = ({{(16-CW-1){1'b0}}, proom} > q_data.size) ?
                        CW'(q_data.size) : proom[CW-1:0];
          end else begin
            left_nxt  = 16'd0;
            chunk_nxt = '0;
          end
          w0 = frame(OP_WREN, 1'b0, 24'd0, 16'd0, 16'd0, 1'b0);
          w1 = frame(OP_RDSR, 1'b0, 24'd0, 16'd1, 16'd0, 1'b0); nw = 2'd2;
          cok_nxt = 1'b1; phase_nxt = PH_WAIT_WEL;
        end
      end
    end else if (q_data.action == ACT_STATUS) begin
      unique case (phase_r)
        PH_WAIT_WEL: begin
          if (wel) begin
            if (op_r == ACT_PROG[1:0]) begin
              w0 = frame(OP_PROGRAM, 1'b1, addr_r, {{(16-CW){1'b0}}, chunk_r}, boff_r, 1'b0);
              polls_nxt = program_poll_limit;
            end else begin
              w0 = frame((op_r == ACT_BLOCK[1:0]) ? OP_BLOCK : OP_SECTOR, 1'b1, addr_r,
                         16'd0, 16'd0, 1'b0);
              polls_nxt = (op_r == ACT_BLOCK[1:0]) ? block_poll_limit : sector_poll_limit;
            end
            w1 = frame(OP_RDSR, 1'b0, 24'd0, 16'd1, 16'd0, 1'b1); nw = 2'd2;
            phase_nxt = PH_POLL;
          end else begin
            w0 = done(1'b0); nw = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        PH_POLL: begin
          if (wip_clr || pdec == 12'd0) begin
            if (!wip_clr) polls_nxt = pdec;
            cok_nxt = wip_clr;
            w0 = frame(OP_WRDI, 1'b0, 24'd0, 16'd0, 16'd0, 1'b0);
            w1 = frame(OP_RDSR, 1'b0, 24'd0, 16'd1, 16'd0, 1'b0); nw = 2'd2;
            phase_nxt = PH_WAIT_WRDI;
          end else begin
            polls_nxt = pdec;
            w0 = frame(OP_RDSR, 1'b0, 24'd0, 16'd1, 16'd0, 1'b1); nw = 2'd1;
          end
        end
        PH_WAIT_WRDI: begin
          if (!cok_r) begin
            w0 = done(1'b0); nw = 2'd1; phase_nxt = PH_IDLE;
          end else if (op_r == ACT_PROG[1:0]) begin
            left_nxt = left_r - step;
            boff_nxt = boff_r + step;
            addr_nxt = addr_r + {8'd0, step};
            if (left_r != step) begin
              chunk_nxt = (left_nxt < 16'(PAGE_BYTES)) ? left_nxt[CW-1:0] : CW'(PAGE_BYTES);
              w0 = frame(OP_WREN, 1'b0, 24'd0, 16'd0, 16'd0, 1'b0);
              w1 = frame(OP_RDSR, 1'b0, 24'd0, 16'd1, 16'd0, 1'b0); nw = 2'd2;
              cok_nxt = 1'b1; phase_nxt = PH_WAIT_WEL;
            end else begin
              w0 = done(1'b1); nw = 2'd1; phase_nxt = PH_IDLE;
            end
          end else begin
            w0 = done(1'b1); nw = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    if (nw == 2'd1) w0.last = 1'b1;
    if (nw == 2'd2) w1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; op_r <= 2'd0; addr_r <= '0; left_r <= '0; chunk_r <= '0;
      boff_r <= '0; polls_r <= '0; cok_r <= 1'b1;
      ocnt_r <= 2'd0; orp_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; op_r <= op_nxt; addr_r <= addr_nxt; left_r <= left_nxt;
        chunk_r <= chunk_nxt; boff_r <= boff_nxt; polls_r <= polls_nxt; cok_r <= cok_nxt;
      end
      // output buffer: new words load only when it is empty or its last word drains this cycle
      if (take && nw != 2'd0) begin
        ocnt_r <= nw; orp_r <= 1'b0;
      end else if (out_valid && out_ready) begin
        ocnt_r <= ocnt_r - 2'd1; orp_r <= ~orp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && nw != 2'd0) begin
      ob_r[0] <= w0;
      ob_r[1] <= w1;
    end
  end

endmodule

[src/spi_nor_flash_command_sequencer_top.sv]
// input words are registered in a queue, result words in an output buffer
// throughput: one input word per cycle while each gives one result word
// and out_ready is high; a two-word input holds off the next until its last drains
// a two-entry queue parts input from the sequencer; no clearing pass
// synchronous active-low reset restores register defaults and idle state
module spi_nor_flash_command_sequencer_top import snfcs_pkg::*; #(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] max_addr_r;
  logic [11:0] prog_lim_r, sect_lim_r, blk_lim_r;
  logic        q_valid, q_ready;
  cls_t        q_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_addr_r <= 24'h7FFFFF;
      prog_lim_r <= 12'd4;
      sect_lim_r <= 12'd300;
      blk_lim_r  <= 12'd3000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ADDR: max_addr_r <= cfg_data;
        REG_PROG_LIM: prog_lim_r <= cfg_data[11:0];
        REG_SECT_LIM: sect_lim_r <= cfg_data[11:0];
        REG_BLK_LIM:  blk_lim_r  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  snfcs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .max_address(max_addr_r),
    .q_valid, .q_ready, .q_data
  );

  snfcs_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .program_poll_limit(prog_lim_r),
    .sector_poll_limit(sect_lim_r),
    .block_poll_limit(blk_lim_r),
    .out_valid, .out_ready, .out_data
  );

endmodule
